FILE: src/ebst_pkg.sv
package ebst_pkg;

    localparam int unsigned CntWidth  = 32;
    localparam int unsigned TimeWidth = 48;
    localparam int unsigned AddrWidth = 4;

    localparam logic [CntWidth-1:0] CntMax = '1;

    localparam logic [15:0] BurstReset    = 16'd5;
    localparam logic [15:0] SampleReset   = 16'd100;
    localparam logic [31:0] IntervalReset = 32'd0;

    // register index, taken from paddr[3:2]
    localparam logic [1:0] RegBurst    = 2'd0;
    localparam logic [1:0] RegSample   = 2'd1;
    localparam logic [1:0] RegInterval = 2'd2;

    localparam logic CmdRecord = 1'b0;
    localparam logic CmdClear  = 1'b1;

    typedef struct packed {
        logic [15:0] burst_count;
        logic [15:0] sample_every;
        logic [31:0] min_interval_ms;
    } t_cfg;

    typedef struct packed {
        logic                emit;
        logic [CntWidth-1:0] suppressed_before;
        logic [CntWidth-1:0] total_seen;
    } t_result;

endpackage

FILE: src/event_burst_sample_throttle.sv
// Channel   Direction  Handshake              Payload
// in        input      i_in_valid/o_in_stall  i_command, i_now_time_ms
// out       output     o_out_valid/i_out_stall o_emit, o_suppressed_before, o_total_seen
// cfg       APB        psel/penable/pready    paddr, pwdata, prdata
//
// One word per cycle unless stalled; each word passes the input, then the result register.
// The counter update is one pass from the input register to the result register.
// A clear word is consumed in that pass and produces no output word.
// Reset is synchronous: counters clear, registers return to their reset values.
// A stalled output word holds and, with a word waiting, pushes the stall back to o_in_stall.
module event_burst_sample_throttle
    import ebst_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_command,
    input  logic [TimeWidth-1:0] i_now_time_ms,

    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_emit,
    output logic [CntWidth-1:0]  o_suppressed_before,
    output logic [CntWidth-1:0]  o_total_seen,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    t_cfg    w_cfg;
    t_result w_result;

    logic                 r_in_valid;
    logic                 r_in_cmd;
    logic [TimeWidth-1:0] r_in_now;
    logic                 r_out_valid;
    t_result              r_out;

    logic w_out_blocked;
    logic w_take;
    logic w_accept;

    ebst_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ebst_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_take),
        .i_command     (r_in_cmd),
        .i_now_time_ms (r_in_now),
        .i_cfg         (w_cfg),
        .o_result      (w_result)
    );

    assign w_out_blocked = r_out_valid && i_out_stall;
    assign w_take        = r_in_valid && !w_out_blocked;
    assign o_in_stall    = r_in_valid && w_out_blocked;
    assign w_accept      = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_take) begin
                r_in_valid <= 1'b0;
            end
            if (!w_out_blocked) begin
                r_out_valid <= w_take && (r_in_cmd == CmdRecord);
            end
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_cmd <= i_command;
            r_in_now <= i_now_time_ms;
        end
        if (w_take) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_emit              = r_out.emit;
    assign o_suppressed_before = r_out.suppressed_before;
    assign o_total_seen        = r_out.total_seen;

endmodule

FILE: src/ebst_regs.sv
module ebst_regs
    import ebst_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    logic w_wr;
    logic [1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[3:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.burst_count     <= BurstReset;
            r_cfg.sample_every    <= SampleReset;
            r_cfg.min_interval_ms <= IntervalReset;
        end else if (w_wr) begin
            unique case (w_idx)
                RegBurst: r_cfg.burst_count <= pwdata[15:0];
                RegSample: begin
                    // a period of zero is stored as one
                    r_cfg.sample_every <= (pwdata[15:0] == 16'd0) ? 16'd1 : pwdata[15:0];
                end
                RegInterval: r_cfg.min_interval_ms <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            RegBurst:    prdata = {16'd0, r_cfg.burst_count};
            RegSample:   prdata = {16'd0, r_cfg.sample_every};
            RegInterval: prdata = r_cfg.min_interval_ms;
            default:     prdata = 32'd0;
        endcase
    end

endmodule

FILE: src/ebst_core.sv
module ebst_core
    import ebst_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic                 i_command,
    input  logic [TimeWidth-1:0] i_now_time_ms,
    input  t_cfg                 i_cfg,
    output t_result              o_result
);

    logic [CntWidth-1:0]  r_total, n_total;
    logic [CntWidth-1:0]  r_supp, n_supp;
    logic [TimeWidth-1:0] r_last, n_last;
    logic                 r_has, n_has;
    logic [15:0]          r_phase, n_phase;

    logic [CntWidth-1:0]  w_total_inc;
    logic                 w_burst_hit;
    logic [15:0]          w_phase_inc;
    logic                 w_sampled;
    logic [TimeWidth:0]   w_deadline;
    logic                 w_floor_ok;
    logic                 w_emit;

    always_comb begin
        w_total_inc = (r_total == CntMax) ? r_total : r_total + 1'b1;
        w_burst_hit = w_total_inc <= {16'd0, i_cfg.burst_count};
        w_phase_inc = r_phase + 16'd1;
        w_sampled   = !w_burst_hit &&
                      ((w_phase_inc >= i_cfg.sample_every) || (w_phase_inc == 16'd0));
        // compare one bit wider so the deadline never wraps
        w_deadline  = {1'b0, r_last} + {17'd0, i_cfg.min_interval_ms};
        w_floor_ok  = (i_cfg.min_interval_ms == 32'd0) || !r_has ||
                      ({1'b0, i_now_time_ms} >= w_deadline);
        w_emit      = w_burst_hit || (w_sampled && w_floor_ok);

        o_result.emit              = w_emit;
        o_result.suppressed_before = w_emit ? r_supp : '0;
        o_result.total_seen        = w_total_inc;

        n_total = r_total;
        n_supp  = r_supp;
        n_last  = r_last;
        n_has   = r_has;
        n_phase = r_phase;
        if (i_fire) begin
            if (i_command == CmdClear) begin
                n_total = '0;
                n_supp  = '0;
                n_last  = '0;
                n_has   = 1'b0;
                n_phase = '0;
            end else begin
                n_total = w_total_inc;
                if (!w_burst_hit) begin
                    n_phase = w_sampled ? 16'd0 : w_phase_inc;
                end
                if (w_emit) begin
                    n_supp = '0;
                    n_last = i_now_time_ms;
                    n_has  = 1'b1;
                end else if (r_supp != CntMax) begin
                    n_supp = r_supp + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_supp  <= '0;
            r_last  <= '0;
            r_has   <= 1'b0;
            r_phase <= '0;
        end else begin
            r_total <= n_total;
            r_supp  <= n_supp;
            r_last  <= n_last;
            r_has   <= n_has;
            r_phase <= n_phase;
        end
    end

    a_emit_resets_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_command == CmdRecord && w_emit) |=> (r_supp == '0 && r_has))
        else $error("suppressed run not cleared after a report");

    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_command == CmdClear) |=> (r_total == '0 && r_phase == '0 && !r_has))
        else $error("clear left counters set");

    a_phase_below_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_command == CmdRecord && !w_burst_hit)
            |=> (r_phase < $past(i_cfg.sample_every)))
        else $error("phase reached the sample period");

    a_no_report_before_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && !w_burst_hit) |-> w_sampled)
        else $error("report past the burst without a candidate");

endmodule
